/* rtl/wsfr_pkg.sv */
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared types and constants of the websocket frame receiver.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  localparam logic [2:0] EV_DATA = 3'd0;
  localparam logic [2:0] EV_CTRL = 3'd1;
  localparam logic [2:0] EV_DONE = 3'd2;
  localparam logic [2:0] EV_OVF  = 3'd3;
  localparam logic [2:0] EV_PING = 3'd4;

  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_CLS  = 4'h8;
  localparam logic [3:0] OP_PING = 4'h9;
  localparam logic [3:0] OP_PONG = 4'hA;

  localparam logic [6:0]  LEN_EXT16   = 7'd126;
  localparam logic [6:0]  LEN_EXT64   = 7'd127;
  localparam logic [6:0]  CTRL_MAX    = 7'd125;
  localparam logic [15:0] CODE_ABSENT = 16'd1005;
  localparam logic [12:0] CAP_RESET   = 13'd4096;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [2:0]  event_res;
    logic        close_seen;
    logic [7:0]  data_byte;
    logic [11:0] byte_index;
    logic [12:0] msg_length;
    logic [3:0]  msg_opcode;
    logic [15:0] close_code;
  } wsfr_res_t;

  typedef struct packed {
    logic      two;
    wsfr_res_t first;
    wsfr_res_t second;
  } wsfr_rec_t;

endpackage

/* rtl/wsfr_ifs.sv */
// ----------------------------------------------------------------------------
// wsfr interfaces
// Valid/ready channels for the byte stream, the events and the capacity write.
// ----------------------------------------------------------------------------
interface wsfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfr_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic        close_seen;
  logic [7:0]  data_byte;
  logic [11:0] byte_index;
  logic [12:0] msg_length;
  logic [3:0]  msg_opcode;
  logic [15:0] close_code;
  logic        last;
  modport source (output valid, output event_res, output close_seen, output data_byte,
                  output byte_index, output msg_length, output msg_opcode,
                  output close_code, output last, input ready);
  modport sink (input valid, input event_res, input close_seen, input data_byte,
                input byte_index, input msg_length, input msg_opcode,
                input close_code, input last, output ready);
endinterface

interface wsfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] rx_capacity;
  modport source (output valid, output rx_capacity, input ready);
  modport sink (input valid, input rx_capacity, output ready);
endinterface

/* rtl/websocket_frame_receiver.sv */
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Websocket frame deframer: header parse, unmasking, message reassembly.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle while the queue has room; the results of a byte
// are written to the queue and then to the output record register before they
// are presented. A byte that yields two results presents them in turn on the
// event output; a four-record queue absorbs that between parser and output.
// Reset clears all parse state and the queue, sets rx_capacity to 4096.
// ----------------------------------------------------------------------------
module websocket_frame_receiver
  import wsfr_pkg::*;
#(
  parameter int MAX_CAPACITY = 4096
) (
  input  logic         clk,
  input  logic         rst,
  wsfr_cfg_if.sink     cfg,
  wsfr_byte_if.sink    stream,
  wsfr_event_if.source events
);

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  wsfr_rec_t push_rec, pop_rec;

  wsfr_front #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .stream    (stream),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_rec  (push_rec)
  );

  wsfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_rec  (push_rec),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec)
  );

  wsfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_rec  (pop_rec),
    .events   (events)
  );

endmodule

/* rtl/wsfr_front.sv */
// ----------------------------------------------------------------------------
// wsfr_front
// Header parser and payload unmasker; packs the results of each byte into a record.
// ----------------------------------------------------------------------------
module wsfr_front
  import wsfr_pkg::*;
#(
  parameter int MAX_CAPACITY = 4096
) (
  input  logic       clk,
  input  logic       rst,
  wsfr_cfg_if.sink   cfg,
  wsfr_byte_if.sink  stream,
  output logic       push_valid,
  input  logic       push_ready,
  output wsfr_rec_t  push_rec
);

  localparam logic [12:0] CapLimit = (MAX_CAPACITY > 8191) ? 13'h1FFF : 13'(MAX_CAPACITY);

  typedef enum logic [2:0] {PH_HDR0, PH_HDR1, PH_EXT, PH_MASK, PH_PAYLOAD} phase_t;

  phase_t      phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  op, op_next;
  logic        masked, masked_next;
  logic [3:0]  ext_left, ext_left_next;
  logic [63:0] remaining, remaining_next;
  logic [31:0] key, key_next;
  logic [1:0]  off, off_next;
  logic [3:0]  msg_op, msg_op_next;
  logic [12:0] msg_len, msg_len_next;
  logic        ovf, ovf_next;
  logic [6:0]  ctrl_cnt, ctrl_cnt_next;
  logic [15:0] close_cap, close_cap_next;
  logic        closed, closed_next;
  logic [12:0] rx_capacity;

  logic        accept;
  logic        len_done, hdr_done, frm_done, frm_emit;
  logic        n_res;
  logic        any_res;
  logic [12:0] cap;
  logic [7:0]  key_byte, d;
  wsfr_res_t   r0, fr;
  logic        is_ctrl_next;

  assign cfg.ready    = 1'b1;
  assign stream.ready = push_ready;
  assign accept       = stream.valid & push_ready;
  assign cap          = (rx_capacity < CapLimit) ? rx_capacity : CapLimit;

  always_comb begin
    phase_next     = phase;
    fin_next       = fin;
    op_next        = op;
    masked_next    = masked;
    ext_left_next  = ext_left;
    remaining_next = remaining;
    key_next       = key;
    off_next       = off;
    msg_op_next    = msg_op;
    msg_len_next   = msg_len;
    ovf_next       = ovf;
    ctrl_cnt_next  = ctrl_cnt;
    close_cap_next = close_cap;
    closed_next    = closed;
    len_done       = 1'b0;
    hdr_done       = 1'b0;
    frm_done       = 1'b0;
    frm_emit       = 1'b0;
    n_res          = 1'b0;
    r0             = '0;
    fr             = '0;
    key_byte       = key[8*(3-off) +: 8];
    d              = stream.rx_byte ^ key_byte;

    if (!closed) begin
      case (phase)
        PH_HDR0: begin
          fin_next   = stream.rx_byte[7];
          op_next    = stream.rx_byte[3:0];
          phase_next = PH_HDR1;
        end
        PH_HDR1: begin
          masked_next    = stream.rx_byte[7];
          remaining_next = '0;
          if (stream.rx_byte[6:0] == LEN_EXT16) begin
            ext_left_next = 4'd2;
            phase_next    = PH_EXT;
          end else if (stream.rx_byte[6:0] == LEN_EXT64) begin
            ext_left_next = 4'd8;
            phase_next    = PH_EXT;
          end else begin
            remaining_next = {57'd0, stream.rx_byte[6:0]};
            len_done       = 1'b1;
          end
        end
        PH_EXT: begin
          remaining_next = {remaining[55:0], stream.rx_byte};
          ext_left_next  = ext_left - 4'd1;
          len_done       = (ext_left == 4'd1);
        end
        PH_MASK: begin
          key_next      = {key[23:0], stream.rx_byte};
          ext_left_next = ext_left - 4'd1;
          hdr_done      = (ext_left == 4'd1);
        end
        PH_PAYLOAD: begin
          off_next       = off + 2'd1;
          remaining_next = remaining - 64'd1;
          if (op == OP_CLS || op == OP_PING || op == OP_PONG) begin
            if (ctrl_cnt < CTRL_MAX) begin
              r0.event_res  = EV_CTRL;
              r0.data_byte  = d;
              r0.byte_index = {5'd0, ctrl_cnt};
              n_res         = 1'b1;
              if (ctrl_cnt < 7'd2) close_cap_next = {close_cap[7:0], d};
              ctrl_cnt_next = ctrl_cnt + 7'd1;
            end
          end else if (!ovf && msg_len < cap) begin
            r0.event_res  = EV_DATA;
            r0.data_byte  = d;
            r0.byte_index = msg_len[11:0];
            n_res         = 1'b1;
            msg_len_next  = msg_len + 13'd1;
          end else begin
            ovf_next = 1'b1;
          end
          frm_done = (remaining == 64'd1);
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase
    end

    if (len_done) begin
      key_next = '0;
      if (masked_next) begin
        ext_left_next = 4'd4;
        phase_next    = PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end

    is_ctrl_next = (op_next == OP_CLS || op_next == OP_PING || op_next == OP_PONG);

    if (hdr_done) begin
      off_next       = '0;
      ctrl_cnt_next  = '0;
      close_cap_next = '0;
      if (!is_ctrl_next && op_next != OP_CONT) begin
        msg_op_next  = op_next;
        msg_len_next = '0;
        ovf_next     = 1'b0;
      end
      if (remaining_next == 64'd0) frm_done = 1'b1;
      else phase_next = PH_PAYLOAD;
    end

    if (frm_done) begin
      phase_next = PH_HDR0;
      if (op_next == OP_PING) begin
        fr.event_res  = EV_PING;
        fr.msg_length = {6'd0, ctrl_cnt_next};
        fr.msg_opcode = OP_PING;
        frm_emit      = 1'b1;
      end else if (op_next == OP_CLS) begin
        fr.event_res  = EV_DONE;
        fr.close_seen = 1'b1;
        fr.msg_length = {6'd0, ctrl_cnt_next};
        fr.msg_opcode = OP_CLS;
        fr.close_code = (ctrl_cnt_next >= 7'd2) ? close_cap_next : CODE_ABSENT;
        closed_next   = 1'b1;
        frm_emit      = 1'b1;
      end else if (!is_ctrl_next && fin_next) begin
        fr.event_res  = ovf_next ? EV_OVF : EV_DONE;
        fr.msg_length = ovf_next ? 13'd0 : msg_len_next;
        fr.msg_opcode = msg_op_next;
        msg_len_next  = '0;
        ovf_next      = 1'b0;
        frm_emit      = 1'b1;
      end
    end

    push_rec.two    = n_res & frm_emit;
    push_rec.first  = n_res ? r0 : fr;
    push_rec.second = fr;
    any_res         = n_res | frm_emit;
  end

  assign push_valid = accept & any_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      fin         <= 1'b0;
      op          <= '0;
      masked      <= 1'b0;
      ext_left    <= '0;
      remaining   <= '0;
      key         <= '0;
      off         <= '0;
      msg_op      <= '0;
      msg_len     <= '0;
      ovf         <= 1'b0;
      ctrl_cnt    <= '0;
      close_cap   <= '0;
      closed      <= 1'b0;
      rx_capacity <= CAP_RESET;
    end else begin
      if (cfg.valid) rx_capacity <= cfg.rx_capacity;
      if (accept) begin
        phase     <= phase_next;
        fin       <= fin_next;
        op        <= op_next;
        masked    <= masked_next;
        ext_left  <= ext_left_next;
        remaining <= remaining_next;
        key       <= key_next;
        off       <= off_next;
        msg_op    <= msg_op_next;
        msg_len   <= msg_len_next;
        ovf       <= ovf_next;
        ctrl_cnt  <= ctrl_cnt_next;
        close_cap <= close_cap_next;
        closed    <= closed_next;
      end
    end
  end

endmodule

/* rtl/wsfr_queue.sv */
// ----------------------------------------------------------------------------
// wsfr_queue
// Short queue of result records between the parser and the event output.
// ----------------------------------------------------------------------------
module wsfr_queue
  import wsfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  wsfr_rec_t push_rec,
  output logic      pop_valid,
  input  logic      pop_ready,
  output wsfr_rec_t pop_rec
);

  wsfr_rec_t             slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  do_push, do_pop;

  assign push_ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_rec    = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_rec;
  end

endmodule

/* rtl/wsfr_back.sv */
// ----------------------------------------------------------------------------
// wsfr_back
// Event output stage; delivers the one or two results of each record in turn.
// ----------------------------------------------------------------------------
module wsfr_back
  import wsfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         pop_valid,
  output logic         pop_ready,
  input  wsfr_rec_t    pop_rec,
  wsfr_event_if.source events
);

  wsfr_rec_t rec;
  logic      rec_valid;
  logic      sel;
  logic      is_last;
  logic      take;
  wsfr_res_t cur;

  assign cur       = sel ? rec.second : rec.first;
  assign is_last   = !rec.two || sel;
  assign take      = !rec_valid || (events.ready && is_last);
  assign pop_ready = take;

  assign events.valid      = rec_valid;
  assign events.event_res  = cur.event_res;
  assign events.close_seen = cur.close_seen;
  assign events.data_byte  = cur.data_byte;
  assign events.byte_index = cur.byte_index;
  assign events.msg_length = cur.msg_length;
  assign events.msg_opcode = cur.msg_opcode;
  assign events.close_code = cur.close_code;
  assign events.last       = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (take) begin
      rec_valid <= pop_valid;
      sel       <= 1'b0;
    end else if (events.ready) begin
      sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pop_valid) rec <= pop_rec;
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the websocket frame receiver. A short table of frames
// with hand-typed results for some bytes comes first. Random frames follow:
// data and control frames, all length encodings, masking and overflow, under
// several capacity settings and idle patterns; a close frame ends the stream.
// Every event is checked in order against the table or a bench deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
  import wsfr_pkg::*;
();

  localparam int CAP_MAX   = 4096;
  localparam int DRAIN     = 16;
  localparam int IDLE_MAX  = 4000;
  localparam int PHASE_LEN = 60;

  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_BIN  = 4'h2;
  localparam logic [3:0] OP_RSV3 = 4'h3;
  localparam logic [3:0] OP_RSVF = 4'hF;

  typedef enum logic [2:0] {ST_HEAD0, ST_HEAD1, ST_EXTLEN, ST_MASKKEY, ST_PAYLOAD} parse_st_e;

  typedef struct packed {
    wsfr_res_t res;
    logic      last;
  } ev_rec_t;

  typedef struct packed {
    logic [7:0] b;
    logic       pinned;
    logic [1:0] n;
    ev_rec_t    r0;
    ev_rec_t    r1;
  } row_t;

  logic clk;
  logic rst;

  wsfr_byte_if  byte_ch ();
  wsfr_event_if ev_ch ();
  wsfr_cfg_if   cfg_ch ();

  websocket_frame_receiver #(.MAX_CAPACITY(CAP_MAX)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .stream (byte_ch),
    .events (ev_ch)
  );

  // deframer state
  parse_st_e   pst;
  logic        fin_bit;
  logic [3:0]  frm_op;
  logic        masked;
  logic [3:0]  ext_left;
  logic [63:0] remaining;
  logic [31:0] key;
  logic [1:0]  off_low;
  logic [3:0]  msg_op;
  logic [12:0] msg_len;
  logic        ovf;
  logic [6:0]  ctl_cnt;
  logic [15:0] close_cap;
  logic        dead;
  logic [12:0] capacity;

  ev_rec_t byte_evs[$];
  ev_rec_t event_q[$];
  row_t    table_q[$];

  logic       pin_on;
  logic [1:0] pin_n;
  ev_rec_t    pin_r0;
  ev_rec_t    pin_r1;

  int gap_pct;
  int stall_pct;
  int n_sent;
  int n_frames;
  int n_checked;
  int n_pings;
  int n_errs;
  int idle_cnt;
  int cap_plan[8];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic ev_rec_t mk_ev(logic [2:0] ev, logic cls, logic [7:0] d, logic [11:0] idx,
                                    logic [12:0] len, logic [3:0] op, logic [15:0] code,
                                    logic lst);
    ev_rec_t e;
    e.res.event_res  = ev;
    e.res.close_seen = cls;
    e.res.data_byte  = d;
    e.res.byte_index = idx;
    e.res.msg_length = len;
    e.res.msg_opcode = op;
    e.res.close_code = code;
    e.last           = lst;
    return e;
  endfunction

  function automatic logic is_ctrl(logic [3:0] op);
    return op == OP_CLS || op == OP_PING || op == OP_PONG;
  endfunction

  task automatic model_reset();
    capacity  = CAP_RESET;
    pst       = ST_HEAD0;
    fin_bit   = 1'b0;
    frm_op    = OP_CONT;
    masked    = 1'b0;
    ext_left  = '0;
    remaining = '0;
    key       = '0;
    off_low   = '0;
    msg_op    = OP_CONT;
    msg_len   = '0;
    ovf       = 1'b0;
    ctl_cnt   = '0;
    close_cap = '0;
    dead      = 1'b0;
  endtask

  task automatic post(logic [2:0] ev, logic cls, logic [7:0] d, logic [11:0] idx,
                      logic [12:0] len, logic [3:0] op, logic [15:0] code);
    byte_evs.push_back(mk_ev(ev, cls, d, idx, len, op, code, 1'b0));
  endtask

  task automatic frame_end();
    pst = ST_HEAD0;
    if (is_ctrl(frm_op)) begin
      if (frm_op == OP_PING) begin
        post(EV_PING, 1'b0, '0, '0, 13'(ctl_cnt), OP_PING, '0);
      end else if (frm_op == OP_CLS) begin
        post(EV_DONE, 1'b1, '0, '0, 13'(ctl_cnt), OP_CLS,
             ctl_cnt >= 7'd2 ? close_cap : CODE_ABSENT);
        dead = 1'b1;
      end
    end else if (fin_bit) begin
      if (ovf) post(EV_OVF, 1'b0, '0, '0, '0, msg_op, '0);
      else post(EV_DONE, 1'b0, '0, '0, msg_len, msg_op, '0);
      msg_len = '0;
      ovf     = 1'b0;
    end
  endtask

  task automatic header_end();
    off_low   = '0;
    ctl_cnt   = '0;
    close_cap = '0;
    if (!is_ctrl(frm_op) && frm_op != OP_CONT) begin
      msg_op  = frm_op;
      msg_len = '0;
      ovf     = 1'b0;
    end
    if (remaining == 0) frame_end();
    else pst = ST_PAYLOAD;
  endtask

  task automatic length_end();
    key = '0;
    if (masked) begin
      ext_left = 4'd4;
      pst      = ST_MASKKEY;
    end else begin
      header_end();
    end
  endtask

  task automatic payload_in(logic [7:0] b);
    logic [7:0]  d;
    logic [12:0] cap_eff;
    d       = b ^ 8'(key >> (8 * (3 - int'(off_low))));
    cap_eff = capacity < 13'(CAP_MAX) ? capacity : 13'(CAP_MAX);
    off_low = off_low + 2'd1;
    remaining = remaining - 64'd1;
    if (is_ctrl(frm_op)) begin
      if (ctl_cnt < CTRL_MAX) begin
        post(EV_CTRL, 1'b0, d, 12'(ctl_cnt), '0, '0, '0);
        if (ctl_cnt < 7'd2) close_cap = {close_cap[7:0], d};
        ctl_cnt = ctl_cnt + 7'd1;
      end
    end else if (!ovf && msg_len < cap_eff) begin
      post(EV_DATA, 1'b0, d, msg_len[11:0], '0, '0, '0);
      msg_len = msg_len + 13'd1;
    end else begin
      ovf = 1'b1;
    end
    if (remaining == 0) frame_end();
  endtask

  // results of one byte land in byte_evs, final one marked last
  task automatic deframe(logic [7:0] b);
    byte_evs.delete();
    if (!dead) begin
      case (pst)
        ST_HEAD0: begin
          fin_bit = b[7];
          frm_op  = b[3:0];
          pst     = ST_HEAD1;
        end
        ST_HEAD1: begin
          masked    = b[7];
          remaining = '0;
          if (b[6:0] == LEN_EXT16) begin
            ext_left = 4'd2;
            pst      = ST_EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            ext_left = 4'd8;
            pst      = ST_EXTLEN;
          end else begin
            remaining = 64'(b[6:0]);
            length_end();
          end
        end
        ST_EXTLEN: begin
          remaining = {remaining[55:0], b};
          ext_left  = ext_left - 4'd1;
          if (ext_left == 0) length_end();
        end
        ST_MASKKEY: begin
          key      = {key[23:0], b};
          ext_left = ext_left - 4'd1;
          if (ext_left == 0) header_end();
        end
        ST_PAYLOAD: payload_in(b);
        default: pst = ST_HEAD0;
      endcase
    end
    if (byte_evs.size() > 0) byte_evs[byte_evs.size() - 1].last = 1'b1;
  endtask

  task automatic chk_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      n_errs++;
      if (n_errs < 40)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    ev_rec_t want;
    if (rst) begin
      model_reset();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) capacity = cfg_ch.rx_capacity;
      if (byte_ch.valid && byte_ch.ready) begin
        deframe(byte_ch.rx_byte);
        if (pin_on) begin
          byte_evs.delete();
          if (pin_n > 0) byte_evs.push_back(pin_r0);
          if (pin_n > 1) byte_evs.push_back(pin_r1);
        end
        foreach (byte_evs[i]) event_q.push_back(byte_evs[i]);
      end
      if (ev_ch.valid && ev_ch.ready) begin
        n_checked++;
        if (ev_ch.event_res == EV_PING) n_pings++;
        if (event_q.size() == 0) begin
          n_errs++;
          if (n_errs < 40)
            $display("%0t: unexpected event %0d expected none got byte %0h", $time,
                     ev_ch.event_res, ev_ch.data_byte);
        end else begin
          want = event_q.pop_front();
          chk_field("event_res", 16'(want.res.event_res), 16'(ev_ch.event_res));
          chk_field("close_seen", 16'(want.res.close_seen), 16'(ev_ch.close_seen));
          chk_field("data_byte", 16'(want.res.data_byte), 16'(ev_ch.data_byte));
          chk_field("byte_index", 16'(want.res.byte_index), 16'(ev_ch.byte_index));
          chk_field("msg_length", 16'(want.res.msg_length), 16'(ev_ch.msg_length));
          chk_field("msg_opcode", 16'(want.res.msg_opcode), 16'(ev_ch.msg_opcode));
          chk_field("close_code", want.res.close_code, ev_ch.close_code);
          chk_field("last", 16'(want.last), 16'(ev_ch.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((byte_ch.valid && byte_ch.ready) || (ev_ch.valid && ev_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= IDLE_MAX) begin
        $display("%0t: no handshake for %0d cycles, %0d events outstanding", $time,
                 idle_cnt, event_q.size());
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    ev_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      ev_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_row(row_t r);
    while ($urandom_range(99) < gap_pct) begin
      byte_ch.valid   <= 1'b0;
      byte_ch.rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= r.b;
    pin_on          <= r.pinned;
    pin_n           <= r.n;
    pin_r0          <= r.r0;
    pin_r1          <= r.r1;
    do @(posedge clk); while (!byte_ch.ready);
    n_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    row_t r;
    r   = '0;
    r.b = b;
    send_row(r);
  endtask

  task automatic dr(logic [7:0] b);
    row_t r;
    r   = '0;
    r.b = b;
    table_q.push_back(r);
  endtask

  task automatic dr_fix(logic [7:0] b, logic [1:0] n, ev_rec_t r0, ev_rec_t r1);
    row_t r;
    r.b      = b;
    r.pinned = 1'b1;
    r.n      = n;
    r.r0     = r0;
    r.r1     = r1;
    table_q.push_back(r);
  endtask

  task automatic set_capacity(logic [12:0] v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.rx_capacity <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // hold the stream until every pending event is out, then let the pipe empty
  task automatic settle();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (event_q.size() != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_frame(logic fin, logic [3:0] op, logic msk, int unsigned len);
    logic [63:0] lv;
    logic [31:0] k;
    int          form;
    lv   = 64'(len);
    k    = $urandom;
    form = $urandom_range(99);
    send_byte({fin, 3'($urandom), op});
    if (len <= 125 && form < 80) begin
      send_byte({msk, lv[6:0]});
    end else if (form < 92 || len > 125 && form < 85) begin
      send_byte({msk, LEN_EXT16});
      send_byte(lv[15:8]);
      send_byte(lv[7:0]);
    end else begin
      send_byte({msk, LEN_EXT64});
      for (int i = 7; i >= 0; i--) send_byte(8'(lv >> (8 * i)));
    end
    if (msk)
      for (int i = 3; i >= 0; i--) send_byte(8'(k >> (8 * i)));
    repeat (len) send_byte(8'($urandom));
    n_frames++;
  endtask

  task automatic random_frame();
    logic [3:0]  op;
    logic [12:0] cap_eff;
    int unsigned len;
    int          sel;
    sel     = $urandom_range(99);
    cap_eff = capacity < 13'(CAP_MAX) ? capacity : 13'(CAP_MAX);
    if (sel < 25) begin
      op = $urandom_range(1) ? OP_PING : OP_PONG;
    end else if (sel < 45) begin
      op = OP_CONT;
    end else if (sel < 85) begin
      op = $urandom_range(1) ? OP_TEXT : OP_BIN;
    end else begin
      do op = 4'($urandom_range(3, 15)); while (is_ctrl(op));
    end
    sel = $urandom_range(99);
    if (is_ctrl(op)) begin
      if (sel < 70) len = $urandom_range(0, 10);
      else if (sel < 85) len = $urandom_range(100, 125);
      else len = $urandom_range(126, 200);
    end else begin
      if (sel < 55) len = $urandom_range(0, 12);
      else if (sel < 75) len = $urandom_range(13, 40);
      else if (sel < 88) len = $urandom_range(41, 300);
      else if (cap_eff <= 300) len = $urandom_range(0, 4) + (cap_eff > 2 ? cap_eff - 2 : 0);
      else len = $urandom_range(0, 5);
    end
    send_frame($urandom_range(99) < 60, op, 1'($urandom), len);
  endtask

  initial begin
    int unsigned close_len;
    rst                <= 1'b1;
    byte_ch.valid      <= 1'b0;
    byte_ch.rx_byte    <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.rx_capacity <= '0;
    pin_on             <= 1'b0;
    pin_n              <= '0;
    pin_r0             <= '0;
    pin_r1             <= '0;
    gap_pct   = 0;
    stall_pct = 0;
    n_sent    = 0;
    n_frames  = 0;
    n_checked = 0;
    n_pings   = 0;
    n_errs    = 0;
    idle_cnt  = 0;
    cap_plan  = '{4096, 0, 5, 8191, 1, 30, 4096, 3};
    cap_plan[5] = $urandom_range(6, 60);

    // directed frames, capacity 2
    dr_fix(8'h81, 0, '0, '0);
    dr_fix(8'h02, 0, '0, '0);
    dr_fix(8'h00, 1, mk_ev(EV_DATA, 1'b0, 8'h00, 12'd0, '0, '0, '0, 1'b1), '0);
    dr_fix(8'hFF, 2, mk_ev(EV_DATA, 1'b0, 8'hFF, 12'd1, '0, '0, '0, 1'b0),
           mk_ev(EV_DONE, 1'b0, '0, '0, 13'd2, OP_TEXT, '0, 1'b1));
    dr_fix(8'h89, 0, '0, '0);
    dr_fix(8'h00, 1, mk_ev(EV_PING, 1'b0, '0, '0, '0, OP_PING, '0, 1'b1), '0);
    // pong without FIN, one byte
    dr_fix(8'h0A, 0, '0, '0);
    dr_fix(8'h01, 0, '0, '0);
    dr_fix(8'h7E, 1, mk_ev(EV_CTRL, 1'b0, 8'h7E, 12'd0, '0, '0, '0, 1'b1), '0);
    // continuation with no message open
    dr(8'h00);
    dr(8'h01);
    dr(8'h5A);
    // masked frame, reserved opcode
    dr(8'h80 | 8'(OP_RSVF));
    dr(8'h81);
    dr(8'hC3);
    dr(8'h5A);
    dr(8'h0F);
    dr(8'hF0);
    dr(8'h96);
    // three bytes into a capacity of two
    dr_fix(8'h80 | 8'(OP_RSV3), 0, '0, '0);
    dr_fix(8'h03, 0, '0, '0);
    dr(8'h41);
    dr(8'h42);
    dr_fix(8'h43, 1, mk_ev(EV_OVF, 1'b0, '0, '0, '0, OP_RSV3, '0, 1'b1), '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_capacity(13'd2);
    foreach (table_q[i]) send_row(table_q[i]);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      set_capacity(13'(cap_plan[ph]));
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 58; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 58; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      begin
        int start;
        start = n_sent;
        while (n_sent - start < PHASE_LEN) random_frame();
      end
    end

    // close ends the stream; later bytes must be ignored
    settle();
    gap_pct = 32;
    case ($urandom_range(3))
      0: close_len = 0;
      1: close_len = 1;
      2: close_len = 2;
      default: close_len = $urandom_range(3, 140);
    endcase
    send_frame(1'b1, OP_CLS, 1'($urandom), close_len);
    repeat (16) send_byte(8'($urandom));
    settle();

    if (event_q.size() != 0) begin
      n_errs++;
      $display("%0t: %0d expected events never arrived", $time, event_q.size());
    end
    $display("tb_top: %0d bytes in %0d random frames, %0d events checked, %0d ping requests",
             n_sent, n_frames, n_checked, n_pings);
    $display("tb_top: capacities 0 to 8191, four idle patterns, close of %0d bytes at the end",
             close_len);
    if (n_errs == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
